// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/ttlc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttlc_pkg
// Types and constants shared by the TTL cache slot manager.
// ----------------------------------------------------------------------------
package ttlc_pkg;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;

  typedef struct packed {
    logic        req_type;
    logic [63:0] key_fingerprint;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
    logic [63:0] observed_ns;
    logic [31:0] lifetime_s;
    logic [63:0] now_ns;
  } req_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [7:0]  slot_number;
    logic [63:0] entry_generation;
    logic [6:0]  removed_count;
    logic        more_left;
  } res_t;

  typedef enum logic [2:0] {
    OUT_REJECTED = 3'd0,
    OUT_UPDATED  = 3'd1,
    OUT_INSERTED = 3'd2,
    OUT_REPLACED = 3'd3,
    OUT_CLEANUP  = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    SRC_FREE,
    SRC_NEVER,
    SRC_VICT
  } src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP_MUL,
    ST_EXP_ADD,
    ST_EXP_CHK,
    ST_SCAN,
    ST_HIT,
    ST_PICK,
    ST_ALLOC,
    ST_SW_INIT,
    ST_SWEEP
  } state_e;

  // Stored slot record.
  typedef struct packed {
    logic [63:0] fp;
    logic [31:0] addr;
    logic [15:0] port;
    logic [63:0] stored;
    logic [63:0] expiry;
  } rec_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic reject_emit;
    logic scan_init;
    logic scan_step;
    logic hit_commit;
    logic pick;
    logic alloc_commit;
    logic sw_init;
    logic sw_step;
    logic sw_emit;
  } cmd_t;

  typedef struct packed {
    logic is_cleanup;
    logic expired_req;
    logic scan_hit;
    logic scan_end;
    logic hit_newer;
    logic sw_end;
  } stat_t;

endpackage

// ===== rtl/ttl_cache_slot_manager.sv =====
// ----------------------------------------------------------------------------
// ttl_cache_slot_manager
// Fixed table of cache slots with time-to-live: store requests and
// batched cleanup of expired slots.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start / busy       req_i (ttlc_pkg::req_t)
//  result    done_o strobe      res_o (ttlc_pkg::res_t)
//  config    cfg_we_i           cfg_wdata_i (capacity_in_use)
//
//  A store computes its expiry, then the key match walks the record memory
//  one slot per cycle through one read port. An expired store is rejected
//  after the expiry check, before any walk; a match ends the walk there.
//  A cleanup visits min(batch, remaining) slots, one slot a cycle.
//  Reset (rst_ni, async) empties every slot at once; no clearing pass.
//  The beat on done_o cannot be held off; a new request may start then.
// ----------------------------------------------------------------------------
module ttl_cache_slot_manager #(
  parameter int SLOTS       = 256,
  parameter int SWEEP_BATCH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ttlc_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic [8:0]     cfg_wdata_i,
  output logic           done_o,
  output ttlc_pkg::res_t res_o
);

  ttlc_pkg::cmd_t  cmd;
  ttlc_pkg::stat_t stat;

  ttlc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  ttlc_dp #(
    .SLOTS       (SLOTS),
    .SWEEP_BATCH (SWEEP_BATCH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/ttlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttlc_ctrl
// Request sequencer: expiry check, key scan, allocation and sweep control.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttlc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ttlc_pkg::stat_t stat_i,
  output ttlc_pkg::cmd_t  cmd_o
);

  ttlc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttlc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ttlc_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ttlc_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ttlc_pkg::ST_EXP_MUL;
        end
      end
      ttlc_pkg::ST_EXP_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = stat_i.is_cleanup ? ttlc_pkg::ST_SW_INIT : ttlc_pkg::ST_EXP_ADD;
      end
      ttlc_pkg::ST_EXP_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ttlc_pkg::ST_EXP_CHK;
      end
      ttlc_pkg::ST_EXP_CHK: begin
        if (stat_i.expired_req) begin
          cmd_o.reject_emit = 1'b1;
          state_d           = ttlc_pkg::ST_IDLE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = ttlc_pkg::ST_SCAN;
        end
      end
      ttlc_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_hit) begin
          state_d = ttlc_pkg::ST_HIT;
        end else if (stat_i.scan_end) begin
          state_d = ttlc_pkg::ST_PICK;
        end
      end
      ttlc_pkg::ST_HIT: begin
        if (stat_i.hit_newer) begin
          cmd_o.hit_commit = 1'b1;
        end else begin
          cmd_o.reject_emit = 1'b1;
        end
        state_d = ttlc_pkg::ST_IDLE;
      end
      ttlc_pkg::ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = ttlc_pkg::ST_ALLOC;
      end
      ttlc_pkg::ST_ALLOC: begin
        cmd_o.alloc_commit = 1'b1;
        state_d            = ttlc_pkg::ST_IDLE;
      end
      ttlc_pkg::ST_SW_INIT: begin
        cmd_o.sw_init = 1'b1;
        state_d       = ttlc_pkg::ST_SWEEP;
      end
      ttlc_pkg::ST_SWEEP: begin
        cmd_o.sw_step = 1'b1;
        if (stat_i.sw_end) begin
          cmd_o.sw_emit = 1'b1;
          state_d       = ttlc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ttlc_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `ASSERT_NXT(a_hit_leaves, (state_q == ttlc_pkg::ST_HIT), !busy)

endmodule

// ===== rtl/ttlc_dp.sv =====
// ----------------------------------------------------------------------------
// ttlc_dp
// Slot record memory, free list, cursors, generation counter and results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttlc_dp #(
  parameter int SLOTS       = 256,
  parameter int SWEEP_BATCH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ttlc_pkg::req_t  req_i,
  input  logic            cfg_we_i,
  input  logic [8:0]      cfg_wdata_i,
  input  ttlc_pkg::cmd_t  cmd_i,
  output ttlc_pkg::stat_t stat_o,
  output logic            done_o,
  output ttlc_pkg::res_t  res_o
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = SW + 1;
  localparam int BW = $clog2(SWEEP_BATCH + 1);
  localparam logic [CW-1:0] NONE = CW'(SLOTS);
  localparam logic [61:0] NS_PER_S_EXT = {32'd0, ttlc_pkg::NS_PER_S};

  ttlc_pkg::rec_t rec_mem [SLOTS];
  logic [CW-1:0]  nf_mem  [SLOTS];

  ttlc_pkg::req_t req_q;
  logic [61:0]    prod_q;
  logic [63:0]    exp_q;
  logic [8:0]     capacity_q;
  logic [CW-1:0]  cap_eff;
  logic [SLOTS-1:0] live_q;

  ttlc_pkg::rec_t rec_rd_q;
  logic [CW-1:0]  nf_rd_q;
  logic           rd_live_q;
  logic [SW-1:0]  rd_idx_q;
  logic           rd_en;
  logic [SW-1:0]  rd_addr;

  logic [CW-1:0]  scan_idx_q;
  logic           scan_pend_q;
  logic           scan_issue;
  logic           hit;

  logic [CW-1:0]  free_head_q;
  logic [CW-1:0]  never_q;
  logic [SW-1:0]  victim_q;
  logic [SW-1:0]  pick_idx;
  ttlc_pkg::src_e pick_src;
  logic [SW-1:0]  alloc_idx_q;
  ttlc_pkg::src_e src_q;
  logic           occupied;
  logic           victim_expired;
  logic [CW-1:0]  alloc_inc;

  logic [SW-1:0]  sw_cursor_q;
  logic [CW-1:0]  sw_rem_q;
  logic [BW-1:0]  sw_cnt_q;
  logic           sw_pend_q;
  logic [6:0]     removed_q;
  logic           sw_issue;
  logic           sw_free;
  logic [CW-1:0]  rem_init;
  logic [CW-1:0]  cur_inc;

  logic [63:0]    gen_take;
  logic [63:0]    gen_q;
  logic           done_q;
  ttlc_pkg::res_t res_q;

  // Effective capacity: zero acts as one, clamp at the table size.
  always_comb begin
    if (capacity_q == 9'd0) begin
      cap_eff = CW'(1);
    end else if (int'(capacity_q) > SLOTS) begin
      cap_eff = NONE;
    end else begin
      cap_eff = CW'(capacity_q);
    end
  end

  assign hit = scan_pend_q && rd_live_q &&
               (rec_rd_q.fp == req_q.key_fingerprint) &&
               (rec_rd_q.addr == req_q.dest_address) &&
               (rec_rd_q.port == req_q.dest_port);
  assign scan_issue = cmd_i.scan_step && (scan_idx_q != NONE) && !hit;
  assign sw_issue   = cmd_i.sw_step && (sw_cnt_q != '0);
  assign sw_free    = cmd_i.sw_step && sw_pend_q && rd_live_q &&
                      (rec_rd_q.expiry <= req_q.now_ns);

  // Allocation source: free list, then never-used, then round-robin victim.
  always_comb begin
    if (free_head_q < NONE) begin
      pick_idx = SW'(free_head_q);
      pick_src = ttlc_pkg::SRC_FREE;
    end else if (never_q < cap_eff) begin
      pick_idx = SW'(never_q);
      pick_src = ttlc_pkg::SRC_NEVER;
    end else begin
      pick_idx = ({1'b0, victim_q} >= cap_eff) ? '0 : victim_q;
      pick_src = ttlc_pkg::SRC_VICT;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (scan_issue) begin
      rd_en   = 1'b1;
      rd_addr = SW'(scan_idx_q);
    end else if (cmd_i.pick) begin
      rd_en   = 1'b1;
      rd_addr = pick_idx;
    end else if (sw_issue) begin
      rd_en   = 1'b1;
      rd_addr = sw_cursor_q;
    end
  end

  assign occupied       = rd_live_q;
  assign victim_expired = occupied && (rec_rd_q.expiry <= req_q.now_ns);
  assign alloc_inc      = CW'(alloc_idx_q) + CW'(1);
  assign cur_inc        = CW'(sw_cursor_q) + CW'(1);
  assign rem_init       = (sw_rem_q == '0) ? cap_eff : sw_rem_q;
  assign gen_take       = (gen_q == 64'd0) ? 64'd1 : gen_q;

  assign stat_o.is_cleanup  = req_q.req_type;
  assign stat_o.expired_req = (exp_q <= req_q.now_ns);
  assign stat_o.scan_hit    = hit;
  assign stat_o.scan_end    = !scan_pend_q && (scan_idx_q == NONE);
  assign stat_o.hit_newer   = (req_q.observed_ns > rec_rd_q.stored);
  assign stat_o.sw_end      = (sw_cnt_q == '0) && !sw_pend_q;

  // Record and next-free memories.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rec_rd_q <= rec_mem[rd_addr];
      nf_rd_q  <= nf_mem[rd_addr];
      rd_idx_q <= rd_addr;
    end
    if (cmd_i.hit_commit) begin
      rec_mem[rd_idx_q] <= '{fp: rec_rd_q.fp, addr: rec_rd_q.addr, port: rec_rd_q.port,
                             stored: req_q.observed_ns, expiry: exp_q};
    end else if (cmd_i.alloc_commit) begin
      rec_mem[alloc_idx_q] <= '{fp: req_q.key_fingerprint, addr: req_q.dest_address,
                                port: req_q.dest_port, stored: req_q.observed_ns,
                                expiry: exp_q};
    end
    if (sw_free) begin
      nf_mem[rd_idx_q] <= free_head_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.mul) begin
      prod_q <= req_q.lifetime_s * NS_PER_S_EXT;
    end
    if (cmd_i.add) begin
      exp_q <= req_q.observed_ns + {2'b00, prod_q};
    end
    if (cmd_i.pick) begin
      alloc_idx_q <= pick_idx;
      src_q       <= pick_src;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= 9'd256;
      live_q      <= '0;
      rd_live_q   <= 1'b0;
      scan_idx_q  <= '0;
      scan_pend_q <= 1'b0;
      free_head_q <= NONE;
      never_q     <= '0;
      victim_q    <= '0;
      sw_cursor_q <= '0;
      sw_rem_q    <= '0;
      sw_cnt_q    <= '0;
      sw_pend_q   <= 1'b0;
      removed_q   <= '0;
      gen_q       <= 64'd1;
      done_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      // A slot freed this cycle and read again at once reads as empty.
      if (rd_en) begin
        rd_live_q <= live_q[rd_addr] && !(sw_free && (rd_addr == rd_idx_q));
      end
      done_q <= 1'b0;

      if (cmd_i.scan_init) begin
        scan_idx_q  <= '0;
        scan_pend_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_pend_q <= scan_issue;
        if (scan_issue) begin
          scan_idx_q <= scan_idx_q + CW'(1);
        end
      end

      if (cmd_i.reject_emit) begin
        done_q <= 1'b1;
        res_q  <= '0;
      end

      if (cmd_i.hit_commit) begin
        gen_q  <= gen_take + 64'd1;
        done_q <= 1'b1;
        res_q  <= '{outcome: ttlc_pkg::OUT_UPDATED, slot_number: 8'(rd_idx_q),
                   entry_generation: gen_take, removed_count: 7'd0, more_left: 1'b0};
      end

      if (cmd_i.pick && (pick_src == ttlc_pkg::SRC_VICT)) begin
        victim_q <= pick_idx;
      end

      if (cmd_i.alloc_commit) begin
        case (src_q)
          ttlc_pkg::SRC_FREE:  free_head_q <= nf_rd_q;
          ttlc_pkg::SRC_NEVER: never_q     <= never_q + CW'(1);
          default: ;
        endcase
        if (occupied) begin
          victim_q <= (alloc_inc >= cap_eff) ? '0 : SW'(alloc_inc);
        end
        live_q[alloc_idx_q] <= 1'b1;
        gen_q  <= gen_take + 64'd1;
        done_q <= 1'b1;
        res_q  <= '{outcome: (!occupied || victim_expired) ? ttlc_pkg::OUT_INSERTED
                                                           : ttlc_pkg::OUT_REPLACED,
                   slot_number: 8'(alloc_idx_q), entry_generation: gen_take,
                   removed_count: 7'd0, more_left: 1'b0};
      end

      if (cmd_i.sw_init) begin
        if ({1'b0, sw_cursor_q} >= cap_eff) begin
          sw_cursor_q <= '0;
        end
        sw_rem_q  <= rem_init;
        sw_cnt_q  <= (int'(rem_init) < SWEEP_BATCH) ? BW'(rem_init) : BW'(SWEEP_BATCH);
        sw_pend_q <= 1'b0;
        removed_q <= '0;
      end else if (cmd_i.sw_step) begin
        sw_pend_q <= sw_issue;
        if (sw_issue) begin
          sw_cursor_q <= (cur_inc == cap_eff) ? '0 : SW'(cur_inc);
          sw_rem_q    <= sw_rem_q - CW'(1);
          sw_cnt_q    <= sw_cnt_q - BW'(1);
        end
        if (sw_free) begin
          live_q[rd_idx_q] <= 1'b0;
          free_head_q      <= CW'(rd_idx_q);
          removed_q        <= removed_q + 7'd1;
        end
      end

      if (cmd_i.sw_emit) begin
        done_q <= 1'b1;
        res_q  <= '{outcome: ttlc_pkg::OUT_CLEANUP, slot_number: 8'd0,
                   entry_generation: 64'd0, removed_count: removed_q,
                   more_left: (sw_rem_q != '0)};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `ASSERT_NXT(a_done_pulse, done_q, !done_q)
  `ASSERT_IMP(a_sweep_cursor, sw_issue, ({1'b0, sw_cursor_q} < cap_eff))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the TTL cache slot manager. Stores and cleanup
// batches are issued through start/busy, each result beat is checked against
// an in-bench slot table model, and capacity is changed between phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NSLOT = 256;
  localparam int BATCH = 64;
  localparam logic [63:0] NS_S = 64'd1000000000;
  localparam logic [8:0] NO_SLOT = 9'd256;
  localparam int WATCHDOG = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  ttlc_pkg::req_t req_i = '0;
  logic cfg_we_i = 1'b0;
  logic [8:0] cfg_wdata_i = '0;
  logic done_o;
  ttlc_pkg::res_t res_o;

  always #5 clk_i = ~clk_i;

  ttl_cache_slot_manager u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .done_o(done_o), .res_o(res_o)
  );

  // slot table shadow
  logic [63:0] s_fp [NSLOT];
  logic [31:0] s_addr [NSLOT];
  logic [15:0] s_port [NSLOT];
  logic [63:0] s_gen [NSLOT];
  logic [63:0] s_exp [NSLOT];
  logic [63:0] s_time [NSLOT];
  logic [8:0] s_next [NSLOT];
  logic [8:0] free_head, never_next, victim, sweep_left;
  logic [7:0] sweep_pos;
  logic [63:0] gen_ctr;
  logic [8:0] capacity;

  ttlc_pkg::res_t expected_q[$];
  int mismatches = 0;
  int unexpected = 0;
  int n_beats = 0;
  int n_store = 0;
  int n_clean = 0;
  int idle_cnt = 0;
  bit no_gaps = 0;

  // key pool keeps matches frequent
  logic [63:0] pool_fp [8];
  logic [31:0] pool_addr [8];
  logic [15:0] pool_port [8];
  logic [63:0] clock_ns;

  function automatic int eff_capacity();
    if (capacity == 0) return 1;
    if (capacity > NSLOT) return NSLOT;
    return int'(capacity);
  endfunction

  function automatic logic [63:0] next_gen();
    logic [63:0] g;
    if (gen_ctr == 64'd0) gen_ctr = 64'd1;
    g = gen_ctr;
    gen_ctr = gen_ctr + 64'd1;
    return g;
  endfunction

  function automatic ttlc_pkg::res_t predict_slot_table(ttlc_pkg::req_t r);
    ttlc_pkg::res_t o;
    int cap, idx, hit, removed, cnt;
    logic [63:0] expiry;
    bit occ, stale;
    o = '0;
    cap = eff_capacity();
    if (r.req_type) begin
      removed = 0;
      if (sweep_pos >= cap) sweep_pos = 0;
      if (sweep_left == 0) sweep_left = 9'(cap);
      cnt = (sweep_left < BATCH) ? int'(sweep_left) : BATCH;
      for (int n = 0; n < cnt; n++) begin
        idx = sweep_pos;
        if (s_gen[idx] != 0 && s_exp[idx] <= r.now_ns) begin
          s_gen[idx] = 0;
          s_exp[idx] = 0;
          s_fp[idx] = 0; s_addr[idx] = 0; s_port[idx] = 0;
          s_next[idx] = free_head;
          free_head = 9'(idx);
          removed++;
        end
        sweep_pos = 8'((idx + 1) % cap);
        sweep_left = sweep_left - 9'd1;
      end
      o.outcome = ttlc_pkg::OUT_CLEANUP;
      o.removed_count = 7'(removed);
      o.more_left = (sweep_left != 0);
      return o;
    end
    expiry = r.observed_ns + 64'(r.lifetime_s) * NS_S;
    o.outcome = ttlc_pkg::OUT_REJECTED;
    if (expiry <= r.now_ns) return o;
    hit = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (hit < 0 && s_gen[i] != 0 && s_fp[i] == r.key_fingerprint &&
          s_addr[i] == r.dest_address && s_port[i] == r.dest_port) hit = i;
    end
    if (hit >= 0) begin
      if (r.observed_ns <= s_time[hit]) return o;
      s_gen[hit] = next_gen();
      s_exp[hit] = expiry;
      s_time[hit] = r.observed_ns;
      o.outcome = ttlc_pkg::OUT_UPDATED;
      o.slot_number = 8'(hit);
      o.entry_generation = s_gen[hit];
      return o;
    end
    if (free_head < NO_SLOT) begin
      idx = free_head;
      free_head = s_next[idx];
      s_next[idx] = NO_SLOT;
    end else if (never_next < cap) begin
      idx = never_next;
      never_next = never_next + 9'd1;
    end else begin
      if (victim >= cap) victim = 0;
      idx = victim;
    end
    occ = (s_gen[idx] != 0);
    stale = occ && s_exp[idx] <= r.now_ns;
    if (occ) victim = 9'((idx + 1) % cap);
    s_fp[idx] = r.key_fingerprint;
    s_addr[idx] = r.dest_address;
    s_port[idx] = r.dest_port;
    s_gen[idx] = next_gen();
    s_exp[idx] = expiry;
    s_time[idx] = r.observed_ns;
    s_next[idx] = NO_SLOT;
    o.outcome = (!occ || stale) ? ttlc_pkg::OUT_INSERTED : ttlc_pkg::OUT_REPLACED;
    o.slot_number = 8'(idx);
    o.entry_generation = s_gen[idx];
    return o;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (done_o) begin
      ttlc_pkg::res_t e;
      n_beats++;
      if (expected_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result beat: %p", res_o);
      end else begin
        e = expected_q.pop_front();
        if (res_o !== e) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp out=%0d slot=%0d gen=%0h rm=%0d more=%0d",
              e.outcome, e.slot_number, e.entry_generation, e.removed_count,
              e.more_left);
            $display("          got out=%0d slot=%0d gen=%0h rm=%0d more=%0d",
              res_o.outcome, res_o.slot_number, res_o.entry_generation,
              res_o.removed_count, res_o.more_left);
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i || !rst_ni) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WATCHDOG) begin
      $display("watchdog expired");
      $display("ttl_cache_slot_manager regression: fail");
      $finish;
    end
  end

  // start stays high after the accepting edge; busy blocks a second accept
  task automatic issue(ttlc_pkg::req_t r);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(predict_slot_table(r));
    if (r.req_type) n_clean++; else n_store++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [8:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity = v;
  endtask

  function automatic ttlc_pkg::req_t store_req(int k, logic [63:0] obs, logic [31:0] life,
                                               logic [63:0] now);
    ttlc_pkg::req_t r;
    r = '0;
    r.key_fingerprint = pool_fp[k];
    r.dest_address = pool_addr[k];
    r.dest_port = pool_port[k];
    r.observed_ns = obs;
    r.lifetime_s = life;
    r.now_ns = now;
    return r;
  endfunction

  function automatic ttlc_pkg::req_t sweep_req(logic [63:0] now);
    ttlc_pkg::req_t r;
    r = '0;
    r.req_type = 1'b1;
    r.now_ns = now;
    return r;
  endfunction

  function automatic ttlc_pkg::req_t random_req();
    ttlc_pkg::req_t r;
    int k;
    r = '0;
    k = $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0) begin
      r = sweep_req(clock_ns + 64'($urandom_range(0, 40)) * NS_S);
      r.key_fingerprint = {$urandom, $urandom};
      return r;
    end
    clock_ns = clock_ns + 64'($urandom_range(0, 3)) * NS_S + 64'($urandom_range(0, 999));
    r = store_req(k, clock_ns - 64'($urandom_range(0, 2000)), $urandom_range(0, 30),
                  clock_ns);
    if ($urandom_range(0, 3) == 0) begin
      r.key_fingerprint = {$urandom, $urandom};
      r.dest_address = $urandom;
      r.dest_port = 16'($urandom);
    end
    if ($urandom_range(0, 19) == 0) begin
      r.observed_ns = {$urandom, $urandom};
      r.lifetime_s = $urandom;
      r.now_ns = {$urandom, $urandom};
    end
    return r;
  endfunction

  typedef struct {
    ttlc_pkg::req_t req;
    bit             has_exp;
    ttlc_pkg::res_t exp;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic add_row(ttlc_pkg::req_t r, bit has_exp, logic [2:0] oc, logic [7:0] sl,
                         logic [63:0] g, logic [6:0] rm, logic mw);
    stim_row_t s;
    s.req = r; s.has_exp = has_exp;
    s.exp = '{outcome: oc, slot_number: sl, entry_generation: g,
              removed_count: rm, more_left: mw};
    directed.push_back(s);
  endtask

  initial begin
    ttlc_pkg::req_t r;
    ttlc_pkg::res_t pred;
    for (int i = 0; i < NSLOT; i++) begin
      s_fp[i] = 0; s_addr[i] = 0; s_port[i] = 0; s_gen[i] = 0;
      s_exp[i] = 0; s_time[i] = 0; s_next[i] = NO_SLOT;
    end
    free_head = NO_SLOT; never_next = 0; victim = 0; gen_ctr = 64'd1;
    sweep_pos = 0; sweep_left = 0; capacity = 9'd256;
    for (int k = 0; k < 8; k++) begin
      pool_fp[k] = {$urandom, $urandom};
      pool_addr[k] = $urandom;
      pool_port[k] = 16'($urandom);
    end
    pool_fp[0] = '1; pool_addr[0] = '1; pool_port[0] = '1;
    pool_fp[1] = '0; pool_addr[1] = '0; pool_port[1] = '0;
    clock_ns = 64'd5000000000;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first insert after reset, expired reject, stale/newer refresh,
    // wrapped expiry, cleanup with nothing expired
    add_row(store_req(0, 64'd100, 32'd1, 64'd0), 1, ttlc_pkg::OUT_INSERTED, 8'd0, 64'd1,
            0, 0);
    add_row(store_req(1, 64'd0, 32'd0, 64'd0), 1, ttlc_pkg::OUT_REJECTED, 0, 0, 0, 0);
    add_row(store_req(1, 64'd0, 32'hFFFF_FFFF, 64'd0), 1, ttlc_pkg::OUT_INSERTED, 8'd1,
            64'd2, 0, 0);
    add_row(store_req(0, 64'd100, 32'd5, 64'd0), 1, ttlc_pkg::OUT_REJECTED, 0, 0, 0, 0);
    add_row(store_req(0, 64'd101, 32'd5, 64'd0), 1, ttlc_pkg::OUT_UPDATED, 8'd0, 64'd3,
            0, 0);
    add_row(store_req(2, 64'hFFFF_FFFF_FFFF_FFFF, 32'd2, 64'd5), 0, 0, 0, 0, 0, 0);
    add_row(store_req(3, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 64'hFFFF_FFFF_FFFF_FFFE),
            0, 0, 0, 0, 0, 0);
    add_row(sweep_req(64'd0), 1, ttlc_pkg::OUT_CLEANUP, 0, 0, 7'd0, 1'b1);
    add_row(sweep_req(64'hFFFF_FFFF_FFFF_FFFF), 0, 0, 0, 0, 0, 0);
    add_row(sweep_req(64'hFFFF_FFFF_FFFF_FFFF), 0, 0, 0, 0, 0, 0);
    add_row(sweep_req(64'hFFFF_FFFF_FFFF_FFFF), 0, 0, 0, 0, 0, 0);
    add_row(store_req(4, 64'd10, 32'd3, 64'd9), 0, 0, 0, 0, 0, 0);
    foreach (directed[i]) begin
      issue(directed[i].req);
      if (directed[i].has_exp) begin
        pred = expected_q[$];
        if (pred !== directed[i].exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: table %p model %p", i, directed[i].exp, pred);
        end
      end
    end

    // small capacity: free list, victims, empty victim, cursor restart
    set_capacity(9'd0);
    for (int i = 0; i < 6; i++) issue(store_req(i % 8, clock_ns, 32'd2, clock_ns));
    set_capacity(9'd3);
    for (int i = 0; i < 8; i++) issue(store_req(5 + i % 3, clock_ns + i, 32'd1, clock_ns));
    issue(sweep_req(clock_ns + 64'd50 * NS_S));
    issue(sweep_req(clock_ns + 64'd50 * NS_S));
    set_capacity(9'd2);
    for (int i = 0; i < 5; i++) issue(store_req(i, clock_ns + 100 + i, 32'd1, clock_ns));
    r = store_req(6, clock_ns + 500, 32'd1, clock_ns);
    r.req_type = 1'b0;
    issue(r);
    set_capacity(9'd511);

    // random phases with varying capacity
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_capacity(9'd256);
        1: set_capacity(9'd5);
        2: set_capacity(9'd1);
        3: set_capacity(9'($urandom_range(2, 40)));
        4: set_capacity(9'd300);
        default: set_capacity(9'd12);
      endcase
      if (ph == 5) no_gaps = 1;
      for (int i = 0; i < 100; i++) begin
        if (i == 50 && !no_gaps) drain();
        issue(random_req());
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    $display("covered %0d stores and %0d cleanup batches, %0d result beats",
             n_store, n_clean, n_beats);
    $display("capacities 0..511 incl. extremes; %0d mismatches, %0d stray beats",
             mismatches, unexpected);
    if (mismatches == 0 && unexpected == 0 && expected_q.size() == 0)
      $display("ttl_cache_slot_manager regression: pass");
    else
      $display("ttl_cache_slot_manager regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ttlc_pkg.sv
rtl/ttlc_ctrl.sv
rtl/ttlc_dp.sv
rtl/ttl_cache_slot_manager.sv
tb/testbench.sv
